FILE: rtl/pirle_pkg.sv
// Shared types and constants of the palette-index run-length encoder.
`default_nettype none

package pirle_pkg;

    localparam int CH_W       = 8;
    localparam int ADDR_W     = 15;
    localparam int CUBE_DEPTH = 32768;
    localparam int IDX_W      = 8;
    localparam int LEN_W      = 11;
    localparam int LEN_MAX    = 2047;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 24;

    typedef struct packed {
        logic [LEN_W-1:0] run_length;
        logic [IDX_W-1:0] color_index;
        logic             row_last;
    } run_beat_t;

endpackage

`default_nettype wire

FILE: rtl/palette_index_run_length_encoder_core.sv
// Palette-index run-length encoder: cube lookup RAM, run tracker and output queue.
//
// Slave channel s_*: one beat per item. s_tuser = 0 loads one cube cell
// (cell_address, cell_value); s_tuser = 1 is an RGB pixel, s_tlast marks
// the last pixel of a row. Master channel m_*: one beat per run
// (run_length, color_index), m_tlast closes the row.
// A pixel reads the cube RAM in the cycle it is taken; the run tracker works
// on the registered read data in the next cycle and pushes zero, one or two
// runs into an 8-entry queue. The first run of a pixel passes the read-data
// register and the queue before it can be taken. Loads give no beat. One
// item is taken per cycle while s_tready is high: the single-port cube RAM
// does one read or one write each cycle, and the tracker closes a run in the
// same cycle. Output is one run per cycle while m_tready is high, so a pixel
// that closes two runs gives two output beats. s_tready falls when the queue
// lacks room for the runs still in flight; a stalled receiver fills the queue
// and then holds off the source. Reset clears the open run and the queue; the
// cube RAM is not cleared and must be loaded before pixels address its cells.
`default_nettype none

module palette_index_run_length_encoder_core #(
    parameter int CUBE_SIDE = 32,
    parameter int ROW_WIDTH = 1024
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // red[7:0], green[15:8], blue[23:16], cell_address[38:24], cell_value[46:39]
    input  wire  [pirle_pkg::S_DATA_W-1:0]    s_tdata,
    // kind
    input  wire                               s_tuser,
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // run_length[10:0], color_index[18:11]
    output logic [pirle_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int QW        = (CUBE_SIDE > 2) ? $clog2(CUBE_SIDE) : 1;
    localparam int FULLW     = (3 * QW > pirle_pkg::ADDR_W) ? 3 * QW : pirle_pkg::ADDR_W;
    localparam int RUN_LIMIT = (ROW_WIDTH < pirle_pkg::LEN_MAX) ? ROW_WIDTH
                                                                : pirle_pkg::LEN_MAX;
    localparam int QDEPTH    = 8;
    localparam int PW        = $clog2(QDEPTH);
    localparam int CW        = PW + 1;

    localparam logic [pirle_pkg::LEN_W-1:0] LIMIT_L = pirle_pkg::LEN_W'(RUN_LIMIT);

    // floor(c * side / 255) via reciprocal, clamped at side - 1
    function automatic logic [QW-1:0] quantize(input logic [pirle_pkg::CH_W-1:0] c);
        logic [15:0] x;
        logic [15:0] q;
        x = 16'(c) * 16'(CUBE_SIDE);
        q = (x + (x >> 8) + 16'd1) >> 8;
        if (q > 16'(CUBE_SIDE - 1)) begin
            q = 16'(CUBE_SIDE - 1);
        end
        return q[QW-1:0];
    endfunction

    logic                                s_fire;
    logic                                is_pixel;
    logic [pirle_pkg::CH_W-1:0]          red;
    logic [pirle_pkg::CH_W-1:0]          green;
    logic [pirle_pkg::CH_W-1:0]          blue;
    logic [pirle_pkg::ADDR_W-1:0]        cell_address;
    logic [pirle_pkg::IDX_W-1:0]         cell_value;
    logic [FULLW-1:0]                    addr_full;
    logic [pirle_pkg::ADDR_W-1:0]        pix_addr;

    logic [pirle_pkg::IDX_W-1:0]         cube_ram [pirle_pkg::CUBE_DEPTH];
    logic [pirle_pkg::IDX_W-1:0]         rd_data_reg;
    logic                                s1_valid_reg;
    logic                                s1_row_end_reg;

    logic [pirle_pkg::IDX_W-1:0]         run_index_reg, run_index_next;
    logic [pirle_pkg::LEN_W-1:0]         run_count_reg, run_count_next;
    logic                                same_run;
    logic [pirle_pkg::LEN_W-1:0]         cnt1;
    logic                                emit_a;
    logic                                emit_b;
    pirle_pkg::run_beat_t                beat_a;
    pirle_pkg::run_beat_t                beat_b;
    pirle_pkg::run_beat_t                first_beat;

    pirle_pkg::run_beat_t                q_mem [QDEPTH];
    logic [PW-1:0]                       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [1:0]                          push_n;
    logic                                pop;
    logic [CW+1:0]                       need;
    pirle_pkg::run_beat_t                head;

    assign red          = s_tdata[7:0];
    assign green        = s_tdata[15:8];
    assign blue         = s_tdata[23:16];
    assign cell_address = s_tdata[38:24];
    assign cell_value   = s_tdata[46:39];

    assign s_fire   = s_tvalid && s_tready;
    assign is_pixel = s_tuser;

    assign addr_full = (FULLW'(quantize(red)) * FULLW'(CUBE_SIDE) + FULLW'(quantize(green)))
                       * FULLW'(CUBE_SIDE) + FULLW'(quantize(blue));
    assign pix_addr  = addr_full[pirle_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (s_fire && !is_pixel) begin
            cube_ram[cell_address] <= cell_value;
        end
        if (s_fire && is_pixel) begin
            rd_data_reg <= cube_ram[pix_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s1_row_end_reg <= 1'b0;
        end else begin
            s1_valid_reg   <= s_fire && is_pixel;
            s1_row_end_reg <= s_tlast;
        end
    end

    // run tracker
    always_comb begin
        same_run       = (run_count_reg != '0) && (rd_data_reg == run_index_reg);
        cnt1           = same_run ? run_count_reg + 1'b1 : pirle_pkg::LEN_W'(1);
        emit_a         = s1_valid_reg && !same_run && (run_count_reg != '0);
        beat_a         = '{run_length: run_count_reg, color_index: run_index_reg,
                           row_last: 1'b0};
        run_index_next = run_index_reg;
        run_count_next = run_count_reg;
        emit_b         = 1'b0;
        if (s1_valid_reg) begin
            run_index_next = rd_data_reg;
            priority if (s1_row_end_reg || (cnt1 >= LIMIT_L)) begin
                emit_b         = 1'b1;
                run_count_next = '0;
            end else begin
                run_count_next = cnt1;
            end
        end
        beat_b     = '{run_length: cnt1, color_index: rd_data_reg,
                       row_last: s1_row_end_reg};
        first_beat = emit_a ? beat_a : beat_b;
        push_n     = 2'(emit_a) + 2'(emit_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_index_reg <= '0;
            run_count_reg <= '0;
        end else begin
            run_index_reg <= run_index_next;
            run_count_reg <= run_count_next;
        end
    end

    // output queue, up to two pushes per cycle
    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {5'b0, head.color_index, head.run_length};
    assign m_tlast  = head.row_last;
    assign pop      = m_tvalid && m_tready;

    assign need     = (CW+2)'(count_reg) + (s1_valid_reg ? (CW+2)'(2) : '0) + (CW+2)'(2);
    assign s_tready = (need <= (CW+2)'(QDEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= first_beat;
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + PW'(1)] <= beat_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pirle_checker.sv
// Port-level checks for the palette-index run-length encoder, bound to the top level.
`default_nettype none

module pirle_checker #(
    parameter int ROW_WIDTH = 1024
) (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [pirle_pkg::M_DATA_W-1:0]     m_tdata,
    input wire                               m_tlast
);

    localparam int RUN_LIMIT = (ROW_WIDTH < pirle_pkg::LEN_MAX) ? ROW_WIDTH
                                                                : pirle_pkg::LEN_MAX;
    localparam logic [pirle_pkg::LEN_W-1:0] LIMIT_L = pirle_pkg::LEN_W'(RUN_LIMIT);

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m beat changed while stalled");

    a_run_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:0] != '0) && (m_tdata[10:0] <= LIMIT_L)
                     && (m_tdata[23:19] == '0))
        else $error("run length out of range or padding set");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("beat offered straight after reset");

endmodule

bind palette_index_run_length_encoder_core pirle_checker #(
    .ROW_WIDTH(ROW_WIDTH)
) u_pirle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: test/pirle_run_checker.sv
`timescale 1ns / 100ps
// Run checker: watches both channels, predicts the encoded runs and compares them beat by beat.
module pirle_run_checker import pirle_pkg::*; #(
    parameter int CUBE_SIDE = 32,
    parameter int ROW_WIDTH = 1024
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    input  wire                s_tready,
    input  wire [S_DATA_W-1:0] s_tdata,
    input  wire                s_tuser,
    input  wire                s_tlast,
    input  wire                m_tvalid,
    input  wire                m_tready,
    input  wire [M_DATA_W-1:0] m_tdata,
    input  wire                m_tlast,
    output int                 runs_waiting,
    output int                 mismatch_total,
    output int                 runs_checked
);

    localparam int CHANNEL_TOP = 255;
    localparam int RUN_CAP     = (ROW_WIDTH < LEN_MAX) ? ROW_WIDTH : LEN_MAX;
    localparam int PRINT_CAP   = 40;

    logic [IDX_W-1:0] cube_copy [CUBE_DEPTH];
    logic [IDX_W-1:0] open_index;
    int               open_len;
    run_beat_t        expected_runs [$];
    int               mismatch_count = 0;
    int               checked = 0;

    initial begin
        runs_waiting   = 0;
        mismatch_total = 0;
        runs_checked   = 0;
        open_len       = 0;
        open_index     = '0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int level_of(input logic [CH_W-1:0] c);
        int q;
        q = c;
        q = q * CUBE_SIDE / CHANNEL_TOP;
        if (q > CUBE_SIDE - 1) begin
            q = CUBE_SIDE - 1;
        end
        return q;
    endfunction

    function automatic void queue_run(input int len, input logic [IDX_W-1:0] idx,
                                      input logic last);
        run_beat_t r;
        r.run_length  = len[LEN_W-1:0];
        r.color_index = idx;
        r.row_last    = last;
        expected_runs.push_back(r);
    endfunction

    // Pixel beat: quantise, look up, extend or close the open run.
    function automatic void encode_pixel(input logic [S_DATA_W-1:0] data, input logic row_end);
        int               cube_pos;
        logic [IDX_W-1:0] idx;
        cube_pos = (level_of(data[0 +: CH_W]) * CUBE_SIDE + level_of(data[CH_W +: CH_W]))
                   * CUBE_SIDE + level_of(data[2*CH_W +: CH_W]);
        idx  = cube_copy[cube_pos % CUBE_DEPTH];
        if (open_len > 0 && idx == open_index) begin
            open_len++;
        end else begin
            if (open_len > 0) begin
                queue_run(open_len, open_index, 1'b0);
            end
            open_index = idx;
            open_len   = 1;
        end
        if (row_end) begin
            queue_run(open_len, open_index, 1'b1);
            open_len = 0;
        end else if (open_len >= RUN_CAP) begin
            queue_run(open_len, open_index, 1'b0);
            open_len = 0;
        end
    endfunction

    always @(posedge aclk) begin
        run_beat_t got;
        run_beat_t want;
        if (!aresetn) begin
            expected_runs.delete();
            open_len   = 0;
            open_index = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    encode_pixel(s_tdata, s_tlast);
                end else begin
                    cube_copy[s_tdata[3*CH_W +: ADDR_W]] = s_tdata[3*CH_W+ADDR_W +: IDX_W];
                end
            end
            if (m_tvalid && m_tready) begin
                got.run_length  = m_tdata[LEN_W-1:0];
                got.color_index = m_tdata[LEN_W +: IDX_W];
                got.row_last    = m_tlast;
                if (expected_runs.size() == 0) begin
                    report_mismatch($sformatf("run beat %0d (len %0d, index %0d) not expected",
                                              checked, got.run_length, got.color_index));
                end else begin
                    want = expected_runs.pop_front();
                    if (got.run_length !== want.run_length) begin
                        report_mismatch($sformatf("run beat %0d: length %0d, expected %0d",
                                                  checked, got.run_length, want.run_length));
                    end
                    if (got.color_index !== want.color_index) begin
                        report_mismatch($sformatf("run beat %0d: index %0d, expected %0d",
                                                  checked, got.color_index, want.color_index));
                    end
                    if (got.row_last !== want.row_last) begin
                        report_mismatch($sformatf("run beat %0d: tlast %0b, expected %0b",
                                                  checked, got.row_last, want.row_last));
                    end
                end
                checked++;
            end
        end
        runs_waiting   <= expected_runs.size();
        mismatch_total <= mismatch_count;
        runs_checked   <= checked;
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Encoder testbench top: clock, reset, beat source, run sink, watchdog and verdict.
module tb_top;
    import pirle_pkg::*;

    localparam int   CUBE_SIDE    = 32;
    localparam int   ROW_WIDTH    = 1024;
    localparam int   RANDOM_ITEMS = 830;
    localparam int   LONG_HOLD    = 400;
    localparam int   IDLE_LIMIT   = 4000;
    localparam int   TAIL_CYCLES  = 24;
    localparam int   CHANNEL_TOP  = 255;
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_COMB} rx_mode_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                s_tlast  = 1'b0;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [M_DATA_W-1:0] m_tdata;
    wire                 m_tlast;

    int runs_waiting;
    int mismatch_total;
    int runs_checked;

    logic     hold_req  = 1'b0;
    logic     hold_seen = 1'b0;
    int       hold_left = 0;
    int       seg_left  = 0;
    int       rx_tick   = 0;
    rx_mode_t rx_mode   = RX_OPEN;
    int       idle_cycles = 0;

    // source bookkeeping
    int               burst_left = 0;
    bit               steady = 1'b0;
    int               items_sent = 0;
    int               n_loads = 0;
    int               n_pixels = 0;
    int               n_rows = 0;
    bit               cell_loaded [CUBE_DEPTH];
    logic [ADDR_W-1:0] loaded_cells [$];
    logic [IDX_W-1:0] common_values [4] = '{8'h00, 8'h3C, 8'hC3, 8'hFF};

    palette_index_run_length_encoder_core #(
        .CUBE_SIDE(CUBE_SIDE),
        .ROW_WIDTH(ROW_WIDTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    pirle_run_checker #(
        .CUBE_SIDE(CUBE_SIDE),
        .ROW_WIDTH(ROW_WIDTH)
    ) run_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .runs_waiting  (runs_waiting),
        .mismatch_total(mismatch_total),
        .runs_checked  (runs_checked)
    );

    always #6 aclk = ~aclk;

    // Sink: changing stall patterns, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_seen) begin
            m_tready  <= 1'b0;
            hold_seen <= 1'b1;
            hold_left <= LONG_HOLD;
        end else begin
            if (seg_left == 0) begin
                rx_mode  <= rx_mode_t'($urandom_range(0, 3));
                seg_left <= $urandom_range(16, 160);
            end else begin
                seg_left <= seg_left - 1;
            end
            rx_tick <= rx_tick + 1;
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_tick[2] ^ rx_tick[0];
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Offers one beat and returns at the edge that takes it; bursts with gaps between.
    task automatic push_beat(input logic kind, input logic [S_DATA_W-1:0] data, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_load(input logic [ADDR_W-1:0] cube_pos, input logic [IDX_W-1:0] value);
        logic [3*CH_W-1:0] junk_rgb;
        junk_rgb = (3*CH_W)'($urandom);
        if (!cell_loaded[cube_pos]) begin
            cell_loaded[cube_pos] = 1'b1;
            loaded_cells.push_back(cube_pos);
        end
        n_loads++;
        push_beat(KIND_LOAD, {1'b0, value, cube_pos, junk_rgb}, 1'($urandom));
    endtask

    task automatic send_pixel_rgb(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                  input logic [CH_W-1:0] b, input logic row_end);
        logic [ADDR_W-1:0] junk_addr;
        logic [IDX_W-1:0]  junk_value;
        junk_addr  = ADDR_W'($urandom);
        junk_value = IDX_W'($urandom);
        n_pixels++;
        if (row_end) begin
            n_rows++;
        end
        push_beat(KIND_PIXEL, {1'b0, junk_value, junk_addr, b, g, r}, row_end);
    endtask

    // Random channel byte inside the quantisation bin of level q.
    function automatic logic [CH_W-1:0] channel_for(input int q);
        int lo;
        int hi;
        lo = (q * CHANNEL_TOP + CUBE_SIDE - 1) / CUBE_SIDE;
        hi = (q == CUBE_SIDE - 1) ? CHANNEL_TOP
                                  : ((q + 1) * CHANNEL_TOP + CUBE_SIDE - 1) / CUBE_SIDE - 1;
        return CH_W'($urandom_range(hi, lo));
    endfunction

    task automatic send_cell_pixel(input logic [ADDR_W-1:0] cube_pos, input logic row_end);
        int qr;
        int qg;
        int qb;
        qb = cube_pos % CUBE_SIDE;
        qg = (cube_pos / CUBE_SIDE) % CUBE_SIDE;
        qr = cube_pos / (CUBE_SIDE * CUBE_SIDE);
        send_pixel_rgb(channel_for(qr), channel_for(qg), channel_for(qb), row_end);
    endtask

    function automatic logic [ADDR_W-1:0] pick_cell();
        return loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
    endfunction

    function automatic logic [IDX_W-1:0] fresh_value();
        if ($urandom_range(0, 9) < 7) begin
            return common_values[$urandom_range(0, 3)];
        end
        return IDX_W'($urandom_range(0, 255));
    endfunction

    task automatic random_load();
        logic [ADDR_W-1:0] cube_pos;
        if ($urandom_range(0, 9) < 7) begin
            cube_pos = ADDR_W'($urandom);
        end else begin
            cube_pos = pick_cell();
        end
        send_load(cube_pos, fresh_value());
    endtask

    initial begin
        int start_items;
        int done_random;
        int len;
        int pick;
        bit hold_done;
        bit pause_done;
        logic [ADDR_W-1:0] cube_pos;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corner cells, channel extremes, merges across cells, row-end cases
        steady = 1'b1;
        send_load(15'h0000, 8'h00);
        send_load(15'h7FFF, 8'hFF);
        send_load(15'h0421, 8'hFF);
        send_load(15'h2AAA, 8'h55);
        send_load(15'h5555, 8'hAA);
        send_pixel_rgb(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel_rgb(8'd7, 8'd3, 8'd0, 1'b0);
        send_load(15'h1234, 8'h3C);                  // load inside an open run
        send_pixel_rgb(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel_rgb(8'd8, 8'd8, 8'd8, 1'b0);      // other cell, same index
        send_pixel_rgb(8'd248, 8'd254, 8'd250, 1'b1);
        send_cell_pixel(15'h0000, 1'b0);
        send_cell_pixel(15'h2AAA, 1'b1);             // index change on the row's last pixel
        send_cell_pixel(15'h5555, 1'b1);             // one-pixel row
        send_load(15'h2AAA, 8'hAA);
        send_cell_pixel(15'h2AAA, 1'b0);
        send_cell_pixel(15'h5555, 1'b1);
        steady = 1'b0;
        start_items = items_sent;

        done_random = 0;
        while (done_random < RANDOM_ITEMS) begin
            if (!hold_done && done_random >= 250) begin
                hold_req  <= 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && done_random >= 550) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (runs_waiting != 0) @(posedge aclk);
                pause_done = 1'b1;
            end
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                len = $urandom_range(1, 6);
                repeat (len) random_load();
            end else if (pick < 88) begin
                len      = $urandom_range(1, 24);
                cube_pos = pick_cell();
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        random_load();
                    end
                    if ($urandom_range(0, 9) >= 6) begin
                        cube_pos = pick_cell();
                    end
                    send_cell_pixel(cube_pos, i == len - 1);
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        random_load();
                    end
                    send_cell_pixel(pick_cell(), 1'($urandom));
                end
            end
            done_random = items_sent - start_items;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (runs_waiting != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d cube loads and %0d pixels over %0d rows; %0d runs compared",
                 n_loads, n_pixels, n_rows, runs_checked);
        $display("included reloaded cells, a long sink hold-off and a drained source pause");
        if (mismatch_total == 0 && runs_waiting == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
